// ----- rtl/core/agv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agv_pkg
// Shared widths, constants and helpers for the arrow glyph vertex block.
// ----------------------------------------------------------------------------
package agv_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 10;
    localparam int HF_BITS     = 10;
    localparam int K_BITS      = 16;
    localparam int K_095       = 62259;
    localparam int HEAD_RESET  = 154;

    localparam int SH          = HF_BITS + 1 + K_BITS;
    // (one - 2h) spans -1022 .. 1024, signed
    localparam int SC_W        = HF_BITS + 2;
    // u*(one-2h)
    localparam int PB_W        = COORD_WIDTH + SC_W;
    // h*K
    localparam int HK_W        = HF_BITS + K_BITS;
    // u*h*K
    localparam int PO_W        = COORD_WIDTH + HK_W + 1;
    // wide sums at scale 2^SH
    localparam int ACC_W       = COORD_WIDTH + SH + 3;
    localparam int TDATA_W     = 4 * COORD_WIDTH;
    localparam int ODATA_W     = 8 * COORD_WIDTH;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [ACC_W-1:0]       t_acc;

    typedef struct packed {
        t_coord cx;
        t_coord cy;
        t_coord u;
        t_coord v;
    } t_glyph;

    typedef struct packed {
        t_coord tail_x;
        t_coord tail_y;
        t_coord tip_x;
        t_coord tip_y;
    } t_ends;

    // round to nearest, ties up, by SH bits, then clamp
    function automatic t_coord round_sat(input t_acc x);
        t_acc r;
        t_acc hi;
        t_acc lo;
        r  = (x + (t_acc'(1) <<< (SH - 1))) >>> SH;
        hi = t_acc'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
        lo = -hi - t_acc'(1);
        if (r > hi) begin
            return t_coord'(hi);
        end else if (r < lo) begin
            return t_coord'(lo);
        end
        return t_coord'(r);
    endfunction

    // half-sum end point with one extra fraction bit, rounded and clamped
    function automatic t_coord end_point(input t_coord c, input t_coord d,
                                         input logic sub);
        logic signed [COORD_WIDTH+1:0] s;
        logic signed [COORD_WIDTH+1:0] r;
        s = sub ? ({c[COORD_WIDTH-1], c, 1'b0} - {{2{d[COORD_WIDTH-1]}}, d})
                : ({c[COORD_WIDTH-1], c, 1'b0} + {{2{d[COORD_WIDTH-1]}}, d});
        r = (s + (COORD_WIDTH+2)'(1)) >>> 1;
        if (r > $signed((COORD_WIDTH+2)'((1 << (COORD_WIDTH - 1)) - 1))) begin
            return {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end else if (r < -$signed((COORD_WIDTH+2)'(1 << (COORD_WIDTH - 1)))) begin
            return {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end
        return t_coord'(r);
    endfunction

endpackage

// ----- rtl/core/agv_mult.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agv_mult
// Stages 1-2: end points, scale factors, then the four component products.
// ----------------------------------------------------------------------------
module agv_mult
    import agv_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  t_glyph                   i_glyph,
    input  logic [HF_BITS-1:0]       i_head,
    output logic                     o_valid,
    output t_ends                    o_ends,
    output t_glyph                   o_glyph,
    output logic                     o_plus,
    output logic signed [PB_W-1:0]   o_bu,
    output logic signed [PB_W-1:0]   o_bv,
    output logic signed [PO_W-1:0]   o_ou,
    output logic signed [PO_W-1:0]   o_ov
);

    logic                    r_v1;
    t_glyph                  r_g1;
    t_ends                   r_e1;
    logic signed [SC_W-1:0]  r_sc;
    logic        [HK_W-1:0]  r_hk;
    logic                    r_plus1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v1    <= i_valid;
            o_valid <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g1           <= i_glyph;
            r_e1.tail_x    <= end_point(i_glyph.cx, i_glyph.u, 1'b1);
            r_e1.tail_y    <= end_point(i_glyph.cy, i_glyph.v, 1'b1);
            r_e1.tip_x     <= end_point(i_glyph.cx, i_glyph.u, 1'b0);
            r_e1.tip_y     <= end_point(i_glyph.cy, i_glyph.v, 1'b0);
            r_sc           <= SC_W'(1 << HF_BITS) - {1'b0, i_head, 1'b0};
            r_hk           <= HK_W'(i_head) * HK_W'(K_095);
            // corner1 takes +offset when v<0, or v==0 and u>=0
            r_plus1        <= i_glyph.v[COORD_WIDTH-1] ||
                              (i_glyph.v == '0 && !i_glyph.u[COORD_WIDTH-1]);
            o_ends         <= r_e1;
            o_glyph        <= r_g1;
            o_plus         <= r_plus1;
            o_bu           <= r_g1.u * r_sc;
            o_bv           <= r_g1.v * r_sc;
            o_ou           <= r_g1.u * $signed({1'b0, r_hk});
            o_ov           <= r_g1.v * $signed({1'b0, r_hk});
        end
    end

endmodule

// ----- rtl/core/agv_corner.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agv_corner
// Stages 3-4: base point and offset sums, then rounding and clamping.
// ----------------------------------------------------------------------------
module agv_corner
    import agv_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  t_ends                    i_ends,
    input  t_glyph                   i_glyph,
    input  logic                     i_plus,
    input  logic signed [PB_W-1:0]   i_bu,
    input  logic signed [PB_W-1:0]   i_bv,
    input  logic signed [PO_W-1:0]   i_ou,
    input  logic signed [PO_W-1:0]   i_ov,
    output logic                     o_valid,
    output logic [ODATA_W-1:0]       o_data
);

    logic  r_v3;
    t_ends r_e3;
    t_acc  r_bx, r_by, r_ox, r_oy;
    t_acc  n_bx, n_by, n_ox, n_oy;

    always_comb begin
        n_bx = (t_acc'(i_glyph.cx) <<< SH) + (t_acc'(i_bu) <<< K_BITS);
        n_by = (t_acc'(i_glyph.cy) <<< SH) + (t_acc'(i_bv) <<< K_BITS);
        n_ox = i_plus ? -t_acc'(i_ov) : t_acc'(i_ov);
        n_oy = i_plus ? t_acc'(i_ou) : -t_acc'(i_ou);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v3    <= i_valid;
            o_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e3   <= i_ends;
            r_bx   <= n_bx;
            r_by   <= n_by;
            r_ox   <= n_ox;
            r_oy   <= n_oy;
            o_data <= {round_sat(r_by - r_oy), round_sat(r_bx - r_ox),
                       round_sat(r_by + r_oy), round_sat(r_bx + r_ox),
                       r_e3.tip_y, r_e3.tip_x, r_e3.tail_y, r_e3.tail_x};
        end
    end

endmodule

// ----- rtl/core/arrow_glyph_vertices_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arrow_glyph_vertices_top
// Arrow glyph vertex generator: tail, tip and two arrowhead corners.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one glyph request per beat: centre and components.
//   m_axis returns tail, tip, corner1 and corner2 for each request, in order.
//   i_cfg_we loads head_fraction (Q0.10); the user writes it only while the
//   block is idle, which the block itself does not enforce.
// Pipeline: four register stages from the accepting edge to m_axis_tvalid.
// Throughput: one glyph per cycle unless stalled; stage 1 forms the end points
//   and the head*0.95 factor, stage 2 the four component products.
// Stall: while m_axis_tready is low with a result pending, the whole
//   pipeline holds; s_axis_tready is high whenever the output stage is
//   empty or being drained, so nothing is lost or repeated.
// Reset: synchronous active-low; clears all valid bits and loads
//   head_fraction with 154 (about 0.15).
// ----------------------------------------------------------------------------
module arrow_glyph_vertices_top
    import agv_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [HF_BITS-1:0]   i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // centre_x, centre_y, comp_u, comp_v
    input  logic [TDATA_W-1:0]   s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tail_x, tail_y, tip_x, tip_y, corner1_x, corner1_y, corner2_x, corner2_y
    output logic [ODATA_W-1:0]   m_axis_tdata
);

    logic [HF_BITS-1:0]     r_head;
    logic                   en;
    logic                   v2;
    t_ends                  e2;
    t_glyph                 g2;
    t_glyph                 g_in;
    logic                   p2;
    logic signed [PB_W-1:0] bu, bv;
    logic signed [PO_W-1:0] ou, ov;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign g_in = '{cx: s_axis_tdata[COORD_WIDTH-1:0],
                    cy: s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH],
                    u:  s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH],
                    v:  s_axis_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= HF_BITS'(HEAD_RESET);
        end else if (i_cfg_we) begin
            r_head <= i_cfg_wdata;
        end
    end

    agv_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_glyph (g_in),
        .i_head  (r_head),
        .o_valid (v2),
        .o_ends  (e2),
        .o_glyph (g2),
        .o_plus  (p2),
        .o_bu    (bu),
        .o_bv    (bv),
        .o_ou    (ou),
        .o_ov    (ov)
    );

    agv_corner u_corner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v2),
        .i_ends  (e2),
        .i_glyph (g2),
        .i_plus  (p2),
        .i_bu    (bu),
        .i_bv    (bv),
        .i_ou    (ou),
        .i_ov    (ov),
        .o_valid (m_axis_tvalid),
        .o_data  (m_axis_tdata)
    );

endmodule

// ----- rtl/core/agv_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agv_checker
// Port-level checks on the arrow glyph vertex block.
// ----------------------------------------------------------------------------
module agv_checker
    import agv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    input  logic               s_axis_tready,
    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic [ODATA_W-1:0] m_axis_tdata
);

    // stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");

    // input side is ready only when the output stage is empty or draining
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready does not follow output stage");

    // with no request entering and no stall, the pipe empties
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tready && !s_axis_tvalid) [*4] |=> !m_axis_tvalid)
        else $error("spurious result");

    // an accepted request with m_axis_tready held high is followed by a result
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && m_axis_tready ##1 m_axis_tready
        ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("result missing after four cycles");

endmodule

bind arrow_glyph_vertices_top agv_checker u_agv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
